// ===== src/ctp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared types and constants for the chromaticity peak tracker.
// ----------------------------------------------------------------------------
package ctp_pkg;

    // Field widths fixed by the pixel and result formats.
    localparam int COMP_W  = 8;
    localparam int SHARE_W = 7;
    localparam int POS_W   = 10;
    localparam int LW_W    = 11;
    localparam int NUM_CH  = 3;

    // Scaled component 100*c needs 15 bits; r+g+b+1 needs 10 bits.
    localparam int NUM_W   = 15;
    localparam int DEN_W   = 10;
    // Divisor aligned to the top quotient bit.
    localparam int DSH_W   = DEN_W + SHARE_W - 1;

    localparam int SHARE_SCALE = 100;
    localparam logic [LW_W-1:0] LW_RESET = 11'd341;

    // One quotient bit is produced per division step.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SHARE_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_COMMIT
    } ctp_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } ctp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic last;
        logic out_busy;
    } ctp_status_t;

endpackage : ctp_pkg
`default_nettype wire

// ===== src/ctp_pixel_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_pixel_if
// Valid/ready channel carrying one RGB pixel and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface ctp_pixel_if;
    import ctp_pkg::*;

    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              last_of_frame;

    modport source (output valid, red, green, blue, last_of_frame, input ready);
    modport sink   (input valid, red, green, blue, last_of_frame, output ready);
endinterface : ctp_pixel_if
`default_nettype wire

// ===== src/ctp_peak_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_peak_if
// Valid/ready channel carrying the three per-channel peak positions.
// ----------------------------------------------------------------------------
interface ctp_peak_if;
    import ctp_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] red_col;
    logic [POS_W-1:0] red_row;
    logic [POS_W-1:0] green_col;
    logic [POS_W-1:0] green_row;
    logic [POS_W-1:0] blue_col;
    logic [POS_W-1:0] blue_row;

    modport source (output valid, red_col, red_row, green_col, green_row,
                    blue_col, blue_row, input ready);
    modport sink   (input valid, red_col, red_row, green_col, green_row,
                    blue_col, blue_row, output ready);
endinterface : ctp_peak_if
`default_nettype wire

// ===== src/ctp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_ctrl
// Sequencer: takes a pixel, runs the shared division steps, then commits.
// ----------------------------------------------------------------------------
module ctp_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ctp_pkg::ctp_status_t status,
    output ctp_pkg::ctp_cmd_t         cmd
);
    import ctp_pkg::*;

    ctp_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state. A final pixel waits in commit while a held result is not taken.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIV;
                    step_next  = LAST_STEP;
                end
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                    state_next = ST_COMMIT;
                else
                    step_next = step_reg - 1'b1;
            end
            ST_COMMIT:
            begin
                if (!(status.last && status.out_busy))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = !(status.last && status.out_busy);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule : ctp_ctrl
`default_nettype wire

// ===== src/ctp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_datapath
// Three restoring-division lanes, peak registers, raster counters and the
// result register.
// ----------------------------------------------------------------------------
module ctp_datapath
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [ctp_pkg::LW_W-1:0]     cfg_wr_data,
    input  wire logic [ctp_pkg::COMP_W-1:0]   red,
    input  wire logic [ctp_pkg::COMP_W-1:0]   green,
    input  wire logic [ctp_pkg::COMP_W-1:0]   blue,
    input  wire logic                         last_of_frame,
    input  wire ctp_pkg::ctp_cmd_t            cmd,
    output ctp_pkg::ctp_status_t              status,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [ctp_pkg::POS_W-1:0]         red_col,
    output logic [ctp_pkg::POS_W-1:0]         red_row,
    output logic [ctp_pkg::POS_W-1:0]         green_col,
    output logic [ctp_pkg::POS_W-1:0]         green_row,
    output logic [ctp_pkg::POS_W-1:0]         blue_col,
    output logic [ctp_pkg::POS_W-1:0]         blue_row
);
    import ctp_pkg::*;

    // Column wrap and row saturation limits, clipped to the counter range.
    localparam int POS_SPAN = 1 << POS_W;
    localparam int WRAP_CAP = (MAX_WIDTH < POS_SPAN) ? MAX_WIDTH : POS_SPAN;
    localparam int ROW_CAP  = (MAX_HEIGHT - 1 < POS_SPAN - 1) ? MAX_HEIGHT - 1
                                                              : POS_SPAN - 1;

    logic [LW_W-1:0]    line_width_reg;
    logic [NUM_W-1:0]   rem_reg  [NUM_CH];
    logic [NUM_W-1:0]   rem_next [NUM_CH];
    logic [SHARE_W-1:0] quo_reg  [NUM_CH];
    logic [SHARE_W-1:0] quo_next [NUM_CH];
    logic [DSH_W-1:0]   dsh_reg, dsh_next;
    logic               last_reg;

    logic [SHARE_W-1:0] best_reg      [NUM_CH];
    logic [SHARE_W-1:0] best_next     [NUM_CH];
    logic [POS_W-1:0]   peak_col_reg  [NUM_CH];
    logic [POS_W-1:0]   peak_col_next [NUM_CH];
    logic [POS_W-1:0]   peak_row_reg  [NUM_CH];
    logic [POS_W-1:0]   peak_row_next [NUM_CH];
    logic [POS_W-1:0]   col_reg, col_next;
    logic [POS_W-1:0]   row_reg, row_next;

    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   out_col_reg [NUM_CH];
    logic [POS_W-1:0]   out_row_reg [NUM_CH];

    logic [COMP_W-1:0]  comp [NUM_CH];
    logic [DEN_W-1:0]   denom;
    logic [LW_W-1:0]    wrap_lim;
    logic [LW_W-1:0]    col_plus;
    logic               emit;

    assign comp[0] = red;
    assign comp[1] = green;
    assign comp[2] = blue;
    assign denom   = DEN_W'(red) + DEN_W'(green) + DEN_W'(blue) + 1'b1;
    assign emit    = cmd.commit && last_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_width_reg <= LW_RESET;
        else if (cfg_wr_en)
            line_width_reg <= cfg_wr_data;
    end

    // Division lanes: load 100*c and the aligned divisor, then one bit a step.
    always_comb
    begin
        dsh_next = dsh_reg;
        for (int i = 0; i < NUM_CH; i++)
        begin
            rem_next[i] = rem_reg[i];
            quo_next[i] = quo_reg[i];
            if (cmd.load)
            begin
                rem_next[i] = NUM_W'(comp[i]) * NUM_W'(SHARE_SCALE);
                quo_next[i] = '0;
            end
            else if (cmd.step)
            begin
                if ({1'b0, rem_reg[i]} >= dsh_reg)
                begin
                    rem_next[i] = rem_reg[i] - dsh_reg[NUM_W-1:0];
                    quo_next[i] = {quo_reg[i][SHARE_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next[i] = {quo_reg[i][SHARE_W-2:0], 1'b0};
                end
            end
        end
        if (cmd.load)
            dsh_next = {denom, {(SHARE_W-1){1'b0}}};
        else if (cmd.step)
            dsh_next = dsh_reg >> 1;
    end

    always_ff @(posedge clk)
    begin
        dsh_reg <= dsh_next;
        for (int i = 0; i < NUM_CH; i++)
        begin
            rem_reg[i] <= rem_next[i];
            quo_reg[i] <= quo_next[i];
        end
        if (cmd.load)
            last_reg <= last_of_frame;
    end

    // Column wrap limit from the configured line width.
    always_comb
    begin
        wrap_lim = line_width_reg;
        if (wrap_lim == '0)
            wrap_lim = LW_W'(1);
        if (wrap_lim > LW_W'(WRAP_CAP))
            wrap_lim = LW_W'(WRAP_CAP);
    end

    assign col_plus = {1'b0, col_reg} + 1'b1;

    // Peak update, raster advance and end-of-frame clear.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        for (int i = 0; i < NUM_CH; i++)
        begin
            best_next[i]     = best_reg[i];
            peak_col_next[i] = peak_col_reg[i];
            peak_row_next[i] = peak_row_reg[i];
            if (cmd.commit && (quo_reg[i] > best_reg[i]))
            begin
                best_next[i]     = quo_reg[i];
                peak_col_next[i] = col_reg;
                peak_row_next[i] = row_reg;
            end
        end
        if (cmd.commit && !last_reg)
        begin
            if (col_plus >= wrap_lim)
            begin
                col_next = '0;
                if (row_reg < POS_W'(ROW_CAP))
                    row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_plus[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                best_reg[i]     <= '0;
                peak_col_reg[i] <= '0;
                peak_row_reg[i] <= '0;
            end
        end
        else if (emit)
        begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                best_reg[i]     <= '0;
                peak_col_reg[i] <= '0;
                peak_row_reg[i] <= '0;
            end
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            for (int i = 0; i < NUM_CH; i++)
            begin
                best_reg[i]     <= best_next[i];
                peak_col_reg[i] <= peak_col_next[i];
                peak_row_reg[i] <= peak_row_next[i];
            end
        end
    end

    // Result register: filled on the final pixel, emptied by a transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                out_col_reg[i] <= peak_col_next[i];
                out_row_reg[i] <= peak_row_next[i];
            end
        end
    end

    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign red_col   = out_col_reg[0];
    assign red_row   = out_row_reg[0];
    assign green_col = out_col_reg[1];
    assign green_row = out_row_reg[1];
    assign blue_col  = out_col_reg[2];
    assign blue_row  = out_row_reg[2];

endmodule : ctp_datapath
`default_nettype wire

// ===== src/chromaticity_peak_tracker.sv =====
// A result is registered at the commit of the final pixel of a frame, after its
// accept and division steps. A pixel is accepted only in idle, so a new one waits
// until the previous one has committed. The shared restoring divider yields one
// share bit per cycle over 7 steps. A final pixel waits in commit while a previous
// result is still not taken. Reset (rst_n low, asynchronous) clears all tracking,
// empties the result register and sets line_width to 341.
`default_nettype none
// ----------------------------------------------------------------------------
// chromaticity_peak_tracker
// Tracks, per colour channel, the first position of the largest
// chromaticity share in a frame and reports the three positions at its end.
// ----------------------------------------------------------------------------
module chromaticity_peak_tracker
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [ctp_pkg::LW_W-1:0]  cfg_wr_data,
    ctp_pixel_if.sink                      pix,
    ctp_peak_if.source                     peaks
);
    import ctp_pkg::*;

    ctp_cmd_t    cmd;
    ctp_status_t status;

    // Sequencer.
    ctp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .in_ready (pix.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, tracking state and result register.
    ctp_datapath
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .red           (pix.red),
        .green         (pix.green),
        .blue          (pix.blue),
        .last_of_frame (pix.last_of_frame),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (peaks.valid),
        .out_ready     (peaks.ready),
        .red_col       (peaks.red_col),
        .red_row       (peaks.red_row),
        .green_col     (peaks.green_col),
        .green_row     (peaks.green_row),
        .blue_col      (peaks.blue_col),
        .blue_row      (peaks.blue_row)
    );

endmodule : chromaticity_peak_tracker
`default_nettype wire

// ===== src/ctp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_checker
// Port-level checks on the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ctp_checker
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     pix_valid,
    input  wire logic                     pix_ready,
    input  wire logic                     peaks_valid,
    input  wire logic                     peaks_ready,
    input  wire logic [ctp_pkg::POS_W-1:0] red_col,
    input  wire logic [ctp_pkg::POS_W-1:0] red_row,
    input  wire logic [ctp_pkg::POS_W-1:0] green_col,
    input  wire logic [ctp_pkg::POS_W-1:0] green_row,
    input  wire logic [ctp_pkg::POS_W-1:0] blue_col,
    input  wire logic [ctp_pkg::POS_W-1:0] blue_row
);
    import ctp_pkg::*;

    // A pixel transfer starts the division, so the input closes next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready) |=> !pix_ready)
        else $error("pixel input stayed open after a transfer");

    // A fresh result follows the pixel transfer that started its division and commit.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(peaks_valid) |-> $past(pix_valid && pix_ready, 9))
        else $error("result appeared without the matching pixel transfer");

    // A result appears only from the commit cycle, when the input is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(peaks_valid) |-> $past(!pix_ready))
        else $error("result appeared while the input was open");

    // A stalled result holds its valid and its positions.
    assert property (@(posedge clk) disable iff (!rst_n)
        (peaks_valid && !peaks_ready) |=> peaks_valid
            && $stable(red_col) && $stable(red_row)
            && $stable(green_col) && $stable(green_row)
            && $stable(blue_col) && $stable(blue_row))
        else $error("stalled result changed");

endmodule : ctp_checker

bind chromaticity_peak_tracker ctp_checker u_ctp_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (pix.valid),
    .pix_ready   (pix.ready),
    .peaks_valid (peaks.valid),
    .peaks_ready (peaks.ready),
    .red_col     (peaks.red_col),
    .red_row     (peaks.red_row),
    .green_col   (peaks.green_col),
    .green_row   (peaks.green_row),
    .blue_col    (peaks.blue_col),
    .blue_row    (peaks.blue_row)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for chromaticity_peak_tracker. Pixel frames are driven
// over the pixel channel at several line widths and traffic patterns. A
// behavioural tracker in the bench works out the three peak positions of each
// frame, and every peak transfer is compared field by field with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module tb;
    import ctp_pkg::*;

    localparam int CLK_PERIOD       = 2;
    localparam int RESET_CYCLES     = 4;
    localparam int FRAME_MAX_WIDTH  = 1024;
    localparam int FRAME_MAX_HEIGHT = 1024;
    localparam int POS_CEILING      = (1 << POS_W) - 1;
    localparam int ROW_CEILING      = (FRAME_MAX_HEIGHT - 1 > POS_CEILING) ?
                                      POS_CEILING : FRAME_MAX_HEIGHT - 1;
    localparam int SETTLE_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int MAX_PRINTED      = 40;
    localparam int DIRECTED_ROWS    = 20;

    // Channel order of the tracking state.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef enum {
        TRAFFIC_STEADY,
        TRAFFIC_SENDER_GAPS,
        TRAFFIC_RECEIVER_STALLS,
        TRAFFIC_BOTH
    } traffic_t;

    typedef struct packed {
        logic [POS_W-1:0] red_col;
        logic [POS_W-1:0] red_row;
        logic [POS_W-1:0] green_col;
        logic [POS_W-1:0] green_row;
        logic [POS_W-1:0] blue_col;
        logic [POS_W-1:0] blue_row;
    } peak_set_t;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic              last;
        logic              typed;
        peak_set_t         want;
    } directed_row_t;

    localparam peak_set_t ORIGIN_PEAKS = '0;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [LW_W-1:0]   cfg_wr_data;

    ctp_pixel_if pix_if ();
    ctp_peak_if  peak_if ();

    // Tracker state mirrored in the bench.
    logic [LW_W-1:0]    line_width_model;
    logic [SHARE_W-1:0] best_share [NUM_CH];
    logic [POS_W-1:0]   peak_col [NUM_CH];
    logic [POS_W-1:0]   peak_row [NUM_CH];
    logic [POS_W-1:0]   col_count;
    logic [POS_W-1:0]   row_count;

    peak_set_t pending_peaks [$];
    int        mismatch_count = 0;
    int        send_gap_pct = 0;
    int        recv_stall_pct = 0;
    int        quiet_cycles = 0;

    // Directed frames at the reset line width. Peaks are typed in only where
    // they are obvious; the rest are left to the tracker.
    directed_row_t directed_table [DIRECTED_ROWS] = '{
        // Black and white single-pixel frames report the origin.
        '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, ORIGIN_PEAKS},
        '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, ORIGIN_PEAKS},
        // Pure primaries in the first three columns.
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd0,   8'd0,   8'd255, 1'b1, 1'b1,
          '{10'd0, 10'd0, 10'd1, 10'd0, 10'd2, 10'd0}},
        // Small values: a later, strictly greater share moves the peak.
        '{8'd1,   8'd0,   8'd0,   1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd1,   8'd1,   8'd1,   1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd2,   8'd0,   8'd0,   1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd0,   8'd1,   8'd0,   1'b1, 1'b1,
          '{10'd3, 10'd0, 10'd4, 10'd0, 10'd2, 10'd0}},
        // An equal share later on keeps the first position.
        '{8'd200, 8'd0,   8'd0,   1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd100, 8'd0,   8'd0,   1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd0,   8'd0,   8'd128, 1'b1, 1'b1,
          '{10'd0, 10'd0, 10'd0, 10'd0, 10'd2, 10'd0}},
        // Mixed colours, predicted.
        '{8'd255, 8'd128, 8'd0,   1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd17,  8'd200, 8'd99,  1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd0,   8'd0,   8'd1,   1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd128, 8'd128, 8'd128, 1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd170, 8'd85,  8'd254, 1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd85,  8'd170, 8'd1,   1'b0, 1'b0, ORIGIN_PEAKS},
        '{8'd254, 8'd127, 8'd64,  1'b1, 1'b0, ORIGIN_PEAKS}
    };

    chromaticity_peak_tracker
    #(
        .MAX_WIDTH  (FRAME_MAX_WIDTH),
        .MAX_HEIGHT (FRAME_MAX_HEIGHT)
    )
    u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pix         (pix_if),
        .peaks       (peak_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Clear every per-frame quantity, as at reset and after a frame closes.
    function automatic void clear_tracking();
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            best_share[ch] = '0;
            peak_col[ch]   = '0;
            peak_row[ch]   = '0;
        end
        col_count = '0;
        row_count = '0;
    endfunction

    // Evaluate one pixel; returns 1 with the frame's peaks on the last pixel.
    function automatic bit track_pixel(input logic [COMP_W-1:0] red,
                                       input logic [COMP_W-1:0] green,
                                       input logic [COMP_W-1:0] blue,
                                       input logic last,
                                       output peak_set_t peaks);
        int comp [NUM_CH];
        int denom;
        int share;
        int wrap;
        comp[CH_RED]   = int'(red);
        comp[CH_GREEN] = int'(green);
        comp[CH_BLUE]  = int'(blue);
        denom = comp[CH_RED] + comp[CH_GREEN] + comp[CH_BLUE] + 1;
        peaks = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            share = (SHARE_SCALE * comp[ch]) / denom;
            if (share > int'(best_share[ch]))
            begin
                best_share[ch] = SHARE_W'(share);
                peak_col[ch]   = col_count;
                peak_row[ch]   = row_count;
            end
        end
        if (last)
        begin
            peaks.red_col   = peak_col[CH_RED];
            peaks.red_row   = peak_row[CH_RED];
            peaks.green_col = peak_col[CH_GREEN];
            peaks.green_row = peak_row[CH_GREEN];
            peaks.blue_col  = peak_col[CH_BLUE];
            peaks.blue_row  = peak_row[CH_BLUE];
            clear_tracking();
            return 1'b1;
        end
        // Column wraps at the line width, held within 1..MAX_WIDTH and the
        // counter range; the row counter saturates.
        wrap = int'(line_width_model);
        if (wrap < 1)
            wrap = 1;
        if (wrap > FRAME_MAX_WIDTH)
            wrap = FRAME_MAX_WIDTH;
        if (wrap > POS_CEILING + 1)
            wrap = POS_CEILING + 1;
        if (int'(col_count) + 1 >= wrap)
        begin
            col_count = '0;
            if (int'(row_count) < ROW_CEILING)
                row_count = row_count + 1'b1;
        end
        else
        begin
            col_count = col_count + 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void set_traffic(input traffic_t traffic);
        send_gap_pct   = (traffic == TRAFFIC_SENDER_GAPS) ? 68 :
                         (traffic == TRAFFIC_BOTH) ? 17 : 0;
        recv_stall_pct = (traffic == TRAFFIC_RECEIVER_STALLS) ? 68 :
                         (traffic == TRAFFIC_BOTH) ? 17 : 0;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [POS_W-1:0] got,
                               input logic [POS_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Append the peaks of a frame that has just closed to the outstanding list.
    function automatic void queue_expected(input peak_set_t peaks);
        pending_peaks.insert(pending_peaks.size(), peaks);
    endfunction

    // Present one pixel, hold it until the transfer, then predict its frame.
    task automatic send_pixel(input logic [COMP_W-1:0] red,
                              input logic [COMP_W-1:0] green,
                              input logic [COMP_W-1:0] blue,
                              input logic last, input logic typed,
                              input peak_set_t want);
        peak_set_t predicted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid         <= 1'b1;
        pix_if.red           <= red;
        pix_if.green         <= green;
        pix_if.blue          <= blue;
        pix_if.last_of_frame <= last;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        if (track_pixel(red, green, blue, last, predicted))
            queue_expected(typed ? want : predicted);
    endtask

    // Stop sending and wait until every outstanding frame has been reported.
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (pending_peaks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic settle_and_configure(input int width, input traffic_t traffic);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LW_W'(width);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        line_width_model = LW_W'(width);
        set_traffic(traffic);
    endtask

    // Mix of content classes so that ties, extremes and dominance all occur.
    task automatic random_pixel(output logic [COMP_W-1:0] red,
                                output logic [COMP_W-1:0] green,
                                output logic [COMP_W-1:0] blue);
        int kind;
        int grey;
        kind = $urandom_range(9);
        grey = $urandom_range(255);
        red   = COMP_W'($urandom_range(255));
        green = COMP_W'($urandom_range(255));
        blue  = COMP_W'($urandom_range(255));
        case (kind)
            4:
            begin
                red   = COMP_W'($urandom_range(128, 255));
                green = COMP_W'($urandom_range(40));
                blue  = COMP_W'($urandom_range(40));
            end
            5:
            begin
                red   = COMP_W'($urandom_range(40));
                green = COMP_W'($urandom_range(40));
                blue  = COMP_W'($urandom_range(128, 255));
                if ($urandom_range(1))
                begin
                    green = blue;
                    blue  = COMP_W'($urandom_range(40));
                end
            end
            6:
            begin
                red   = COMP_W'(grey);
                green = COMP_W'(grey);
                blue  = COMP_W'(grey);
            end
            7:
            begin
                red   = $urandom_range(1) ? 8'd255 : 8'd0;
                green = $urandom_range(1) ? 8'd255 : 8'd0;
                blue  = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            8, 9:
            begin
                red   = COMP_W'($urandom_range(3));
                green = COMP_W'($urandom_range(3));
                blue  = COMP_W'($urandom_range(3));
            end
            default:
            begin
            end
        endcase
    endtask

    // Short frames of random content; the phase always closes its last frame.
    task automatic run_phase(input int width, input int items, input traffic_t traffic);
        int len;
        int sent;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        settle_and_configure(width, traffic);
        sent = 0;
        while (sent < items)
        begin
            len = ($urandom_range(3) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 30);
            for (int k = 0; k < len && sent < items; k++)
            begin
                random_pixel(red, green, blue);
                send_pixel(red, green, blue, (k == len - 1) || (sent == items - 1),
                           1'b0, ORIGIN_PEAKS);
                sent++;
            end
        end
    endtask

    // One long grey frame with a pure primary planted per channel, so that
    // the peaks land on far columns or rows.
    task automatic long_frame(input int width, input int len, input int red_at,
                              input int green_at, input int blue_at,
                              input traffic_t traffic);
        logic [COMP_W-1:0] level;
        logic [COMP_W-1:0] primary;
        settle_and_configure(width, traffic);
        for (int k = 0; k < len; k++)
        begin
            level   = COMP_W'($urandom_range(255));
            primary = COMP_W'($urandom_range(128, 255));
            if (k == red_at)
                send_pixel(primary, '0, '0, k == len - 1, 1'b0, ORIGIN_PEAKS);
            else if (k == green_at)
                send_pixel('0, primary, '0, k == len - 1, 1'b0, ORIGIN_PEAKS);
            else if (k == blue_at)
                send_pixel('0, '0, primary, k == len - 1, 1'b0, ORIGIN_PEAKS);
            else
                send_pixel(level, level, level, k == len - 1, 1'b0, ORIGIN_PEAKS);
        end
    endtask

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        peak_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each peak transfer with the oldest prediction.
    always @(posedge clk)
    begin : peak_checker
        peak_set_t want;
        if (rst_n && peak_if.valid && peak_if.ready)
        begin
            if (pending_peaks.size() == 0)
            begin
                report_mismatch("peak transfer with no frame outstanding");
            end
            else
            begin
                want = pending_peaks.pop_front();
                check_field("red_col",   peak_if.red_col,   want.red_col);
                check_field("red_row",   peak_if.red_row,   want.red_row);
                check_field("green_col", peak_if.green_col, want.green_col);
                check_field("green_row", peak_if.green_row, want.green_row);
                check_field("blue_col",  peak_if.blue_col,  want.blue_col);
                check_field("blue_row",  peak_if.blue_row,  want.blue_row);
            end
        end
    end

    // Watchdog: too long without a transfer on either channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_if.valid && pix_if.ready) || (peak_if.valid && peak_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int width;
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        pix_if.valid         = 1'b0;
        pix_if.red           = '0;
        pix_if.green         = '0;
        pix_if.blue          = '0;
        pix_if.last_of_frame = 1'b0;
        peak_if.ready        = 1'b0;
        line_width_model     = LW_RESET;
        clear_tracking();
        set_traffic(TRAFFIC_STEADY);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset line width.
        foreach (directed_table[i])
            send_pixel(directed_table[i].red, directed_table[i].green,
                       directed_table[i].blue, directed_table[i].last,
                       directed_table[i].typed, directed_table[i].want);

        // Widest line, zero width, single column and an oversized width.
        run_phase(FRAME_MAX_WIDTH, 40, TRAFFIC_SENDER_GAPS);
        run_phase(0, 30, TRAFFIC_RECEIVER_STALLS);
        run_phase(1, 30, TRAFFIC_BOTH);
        run_phase((1 << LW_W) - 1, 30, TRAFFIC_STEADY);

        // Oversized width wraps at the maximum: peak in the last column.
        long_frame((1 << LW_W) - 1, FRAME_MAX_WIDTH + 2, FRAME_MAX_WIDTH - 1,
                   $urandom_range(900, FRAME_MAX_WIDTH + 1),
                   $urandom_range(0, FRAME_MAX_WIDTH + 1), TRAFFIC_BOTH);
        // One pixel per line runs the row counter into saturation.
        long_frame(0, ROW_CEILING + 7, $urandom_range(ROW_CEILING + 1, ROW_CEILING + 6),
                   ROW_CEILING, $urandom_range(0, ROW_CEILING + 6), TRAFFIC_STEADY);

        // Random widths under each traffic pattern in turn.
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:       width = $urandom_range(1, FRAME_MAX_WIDTH);
                1:       width = $urandom_range(2, 3);
                2:       width = $urandom_range(0, (1 << LW_W) - 1);
                default: width = int'(LW_RESET);
            endcase
            run_phase(width, $urandom_range(25, 40), traffic_t'(p % 4));
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule : tb
